@@ src/assert_macros.svh @@
// assertion macros included by the rtl file sorted_two_way_merge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold on a clock edge, off while reset is low
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ src/stwm_pkg.sv @@
// types and constants of the sorted two-way merge block
`default_nettype none

package stwm_pkg;

  // entries in each list store
  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SUM_W      = CNT_W + 1;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CMD_W      = 2;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_DEPTH);

  // request command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_MERGE    = 2'd2
  } cmd_e;

  // control states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_e;

endpackage

`default_nettype wire

@@ src/sorted_two_way_merge.sv @@
// sorted two-way merge: two list memories, append path and merge sequencer
//
// channel  dir  tdata                  tuser                          tlast
// s_axis   in   value (signed, 32)     cmd (2)                        -
// m_axis   out  merged_value (32)      from_list_b [0], dropped [1]   last
//
// append requests are taken back to back
// a merge request emits count_a + count_b results, one per cycle without
// output stalls; the rate is set by one read per cycle of each list memory
// the input holds off (tready low) from the merge request until the last
// result is loaded; output stalls pause the merge sequencer
// reset clears the fill counts, merge indices, drop flag, output valid and control state only
`default_nettype none

module sorted_two_way_merge
  import stwm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  wire logic [CMD_W-1:0]  s_axis_tuser,   // [1:0] cmd
  // result stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [DATA_W-1:0]      m_axis_tdata,   // [31:0] merged_value
  output logic [1:0]             m_axis_tuser,   // [0] from_list_b, [1] dropped
  output logic                   m_axis_tlast
);

  // list memories and their registered read data
  logic [DATA_W-1:0] mem_a [LIST_DEPTH];
  logic [DATA_W-1:0] mem_b [LIST_DEPTH];
  logic [DATA_W-1:0] rd_a_q, rd_b_q;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CNT_W-1:0] ia_q, ia_d, ib_q, ib_d;
  logic             drop_q, drop_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_fromb_q, out_fromb_d;
  logic              out_last_q, out_last_d;
  logic              out_drop_q, out_drop_d;

  logic       in_fire, out_free, out_load, take_a, load_last;
  logic       we_a, we_b;
  cmd_e       cmd;
  logic [SUM_W-1:0] total, taken;

  assign cmd      = cmd_e'(s_axis_tuser);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign total    = SUM_W'(cnt_a_q) + SUM_W'(cnt_b_q);
  assign taken    = SUM_W'(ia_q) + SUM_W'(ib_q);

  // head selection: an exhausted list yields to the other; else a goes first only when strictly less than b
  always_comb begin
    if (ia_q >= cnt_a_q) begin
      take_a = 1'b0;
    end else if (ib_q >= cnt_b_q) begin
      take_a = 1'b1;
    end else begin
      take_a = $signed(rd_a_q) < $signed(rd_b_q);
    end
  end

  assign load_last = (taken + SUM_W'(1)) == total;

  // next state, append path and merge stepping
  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    drop_d      = drop_q;
    we_a        = 1'b0;
    we_b        = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_fromb_d = out_fromb_q;
    out_last_d  = out_last_q;
    out_drop_d  = out_drop_q;
    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        ia_d = '0;
        ib_d = '0;
        if (in_fire) begin
          case (cmd)
            CMD_APPEND_A: begin
              if (cnt_a_q < CNT_FULL) begin
                we_a    = 1'b1;
                cnt_a_d = cnt_a_q + CNT_W'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            CMD_APPEND_B: begin
              if (cnt_b_q < CNT_FULL) begin
                we_b    = 1'b1;
                cnt_b_d = cnt_b_q + CNT_W'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            CMD_MERGE: begin
              if (total != '0) begin
                state_d = ST_MERGE;
              end
            end
            default: begin
              // unused code, nothing to do
            end
          endcase
        end
      end
      ST_MERGE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_data_d  = take_a ? rd_a_q : rd_b_q;
          out_fromb_d = !take_a;
          out_last_d  = load_last;
          out_drop_d  = drop_q;
          if (take_a) begin
            ia_d = ia_q + CNT_W'(1);
          end else begin
            ib_d = ib_q + CNT_W'(1);
          end
          if (load_last) begin
            state_d = ST_IDLE;
            cnt_a_d = '0;
            cnt_b_d = '0;
            ia_d    = '0;
            ib_d    = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // list a memory: append write, head read at the next index
  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[cnt_a_q[IDX_W-1:0]] <= s_axis_tdata;
    end
    rd_a_q <= mem_a[ia_d[IDX_W-1:0]];
  end

  // list b memory
  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[cnt_b_q[IDX_W-1:0]] <= s_axis_tdata;
    end
    rd_b_q <= mem_b[ib_d[IDX_W-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ia_q        <= '0;
      ib_q        <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ia_q        <= ia_d;
      ib_q        <= ib_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_fromb_q <= out_fromb_d;
    out_last_q  <= out_last_d;
    out_drop_q  <= out_drop_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_drop_q, out_fromb_q};
  assign m_axis_tlast  = out_last_q;

  // checks on the merge sequencer and fill counts
`include "assert_macros.svh"

  `ASSERT_CLK(a_cnt_bound, (cnt_a_q <= CNT_FULL) && (cnt_b_q <= CNT_FULL), "fill count over depth")
  `ASSERT_CLK(a_idx_bound, (state_q == ST_MERGE) |-> ((ia_q <= cnt_a_q) && (ib_q <= cnt_b_q)), "merge index past fill count")
  `ASSERT_CLK(a_last_empties, (out_load && load_last) |=> ((state_q == ST_IDLE) && (cnt_a_q == '0) && (cnt_b_q == '0)), "lists not emptied after last result")
  `ASSERT_NEVER(a_drop_sticky, $fell(drop_q), "drop flag cleared outside reset")

endmodule

`default_nettype wire

@@ dv/tb_sorted_two_way_merge.sv @@
// testbench for sorted_two_way_merge: random appends and merges checked against a list model
`timescale 1ns / 100ps

module tb_sorted_two_way_merge
  import stwm_pkg::*;
();

  // cmd code the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    bit                drain;   // hold off until every merge result has arrived
  } merge_req_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    bit                       from_b;
    bit                       last;
    bit                       dropped;
  } merged_item_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;   // [31:0] value
  logic [CMD_W-1:0]  s_axis_tuser = '0;   // [1:0] cmd
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // [31:0] merged_value
  logic [1:0]        m_axis_tuser;        // [0] from_list_b, [1] dropped
  logic              m_axis_tlast;

  // stimulus and expected results
  merge_req_t   req_q[$];
  merged_item_t merged_due[$];
  int           fed_count = 0;
  int           bad_count = 0;
  bit           req_taken = 1'b0;

  // model state: the two list stores and the sticky drop flag
  int list_a[$];
  int list_b[$];
  bit drop_seen = 1'b0;

  sorted_two_way_merge uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #400000;
    $display("[sorted_two_way_merge] ERROR");
    $finish;
  end

  // emit both lists in merged order, b wins ties, then empty them
  task automatic merge_lists();
    merged_item_t r;
    int total;
    int n;
    bit take_b;
    total = list_a.size() + list_b.size();
    for (n = 0; n < total; n++) begin
      if (list_a.size() == 0) take_b = 1'b1;
      else if (list_b.size() == 0) take_b = 1'b0;
      else take_b = !(list_a[0] < list_b[0]);
      r.value   = take_b ? list_b.pop_front() : list_a.pop_front();
      r.from_b  = take_b;
      r.last    = (n + 1 == total);
      r.dropped = drop_seen;
      merged_due.push_back(r);
    end
  endtask

  // apply one accepted request to the model
  task automatic take_request(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
    if (cmd == CMD_APPEND_A) begin
      if (list_a.size() >= LIST_DEPTH) drop_seen = 1'b1;
      else list_a.push_back(value);
    end else if (cmd == CMD_APPEND_B) begin
      if (list_b.size() >= LIST_DEPTH) drop_seen = 1'b1;
      else list_b.push_back(value);
    end else if (cmd == CMD_MERGE) begin
      merge_lists();
    end
  endtask

  task automatic report_fault(string what, merged_item_t want);
    bad_count++;
    if (bad_count <= MAX_REPORTS) begin
      $display("%0t %s: got value %0d from_b %b last %b dropped %b", $realtime, what,
               $signed(m_axis_tdata), m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
      $display("    expected value %0d from_b %b last %b dropped %b",
               want.value, want.from_b, want.last, want.dropped);
    end
  endtask

  // monitor: requests feed the model, results are checked in order
  always @(posedge clk_i) begin : watch_ports
    merged_item_t want;
    if (!rst_ni) begin
      req_taken = 1'b0;
    end else begin
      req_taken = s_axis_tvalid && s_axis_tready;
      if (req_taken) take_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (merged_due.size() == 0) begin
          want = '{default: 0};
          report_fault("result with none expected", want);
        end else begin
          want = merged_due.pop_front();
          if (m_axis_tdata !== want.value || m_axis_tuser[0] !== want.from_b ||
              m_axis_tlast !== want.last || m_axis_tuser[1] !== want.dropped) begin
            report_fault("result mismatch", want);
          end
        end
      end
    end
  end

  // request driver: bursts with random gaps, optional drain before a request
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin : drive_req
    logic              nxt_valid;
    logic [DATA_W-1:0] nxt_data;
    logic [CMD_W-1:0]  nxt_user;
    merge_req_t        cur;
    nxt_valid = s_axis_tvalid;
    nxt_data  = s_axis_tdata;
    nxt_user  = s_axis_tuser;
    if (rst_ni && !(s_axis_tvalid && !req_taken)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_q.size() > 0 && !(req_q[0].drain && merged_due.size() > 0)) begin
        cur       = req_q.pop_front();
        nxt_valid = 1'b1;
        nxt_data  = cur.value;
        nxt_user  = cur.cmd;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 10)
                                                   : $urandom_range(0, 3);
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 12);
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= nxt_data;
    s_axis_tuser  <= nxt_user;
  end

  // result receiver: stall modes of random length
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_phase = 0;

  always @(negedge clk_i) begin : drive_ready
    logic nxt_ready;
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(10, 60);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:   nxt_ready = 1'b1;
      RX_COIN:   nxt_ready = ($urandom_range(0, 1) == 1);
      RX_SPARSE: nxt_ready = ($urandom_range(0, 3) == 0);
      default:   nxt_ready = (rx_phase % 3 == 0);
    endcase
    m_axis_tready <= nxt_ready;
  end

  task automatic add_req(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value, bit drain = 1'b0);
    merge_req_t r;
    r.cmd   = cmd;
    r.value = value;
    r.drain = drain;
    req_q.push_back(r);
    if (cmd != CMD_UNUSED) fed_count++;
  endtask

  // element source: full range, a narrow band that forces ties, or the extremes
  function automatic int pick_value(int style);
    int edges[7];
    edges = '{32'h8000_0000, 32'h8000_0001, -1, 0, 1, 32'h7fff_fffe, 32'h7fff_ffff};
    case (style)
      0:       return $urandom;
      1:       return int'($urandom_range(0, 8)) - 4;
      default: return edges[$urandom_range(0, 6)];
    endcase
  endfunction

  function automatic int pick_size();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return LIST_DEPTH;
    if (roll < 4) return $urandom_range(0, LIST_DEPTH);
    return $urandom_range(0, 6);
  endfunction

  // one list load: runs (usually sorted ascending) appended in random interleave, then a merge
  task automatic add_run(int na, int nb);
    int  vals_a[$];
    int  vals_b[$];
    int  style;
    bit  in_order;
    bit  pick_b;
    style    = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    in_order = ($urandom_range(0, 9) != 0);
    repeat (na) vals_a.push_back(pick_value(style));
    repeat (nb) vals_b.push_back(pick_value(style));
    if (in_order) begin
      vals_a.sort();
      vals_b.sort();
    end
    while (vals_a.size() + vals_b.size() > 0) begin
      if (vals_a.size() == 0) pick_b = 1'b1;
      else if (vals_b.size() == 0) pick_b = 1'b0;
      else pick_b = ($urandom_range(0, 1) == 1);
      if (pick_b) add_req(CMD_APPEND_B, vals_b.pop_front());
      else add_req(CMD_APPEND_A, vals_a.pop_front());
      // noise: ignored code or a premature merge
      if ($urandom_range(0, 29) == 0) add_req(CMD_UNUSED, $urandom);
      if ($urandom_range(0, 39) == 0) add_req(CMD_MERGE, $urandom);
    end
    add_req(CMD_MERGE, $urandom, $urandom_range(0, 9) == 0);
  endtask

  // stimulus and end of run
  initial begin
    // directed: empty merge, ignored code, extremes and ties
    add_req(CMD_MERGE, 32'h0);
    add_req(CMD_UNUSED, 32'hffff_ffff);
    add_req(CMD_APPEND_A, 32'h8000_0000);
    add_req(CMD_APPEND_A, 32'hffff_ffff);
    add_req(CMD_APPEND_A, 32'h0);
    add_req(CMD_APPEND_A, 32'h7fff_ffff);
    add_req(CMD_APPEND_B, 32'h8000_0000);
    add_req(CMD_APPEND_B, 32'h0);
    add_req(CMD_APPEND_B, 32'h0);
    add_req(CMD_APPEND_B, 32'h7fff_ffff);
    add_req(CMD_MERGE, 32'hffff_ffff);
    // only list a, sender waits for the previous merge to drain
    add_req(CMD_APPEND_A, 32'd5, 1'b1);
    add_req(CMD_APPEND_A, 32'd7);
    add_req(CMD_MERGE, 32'h0);
    // only list b
    add_req(CMD_APPEND_B, -3);
    add_req(CMD_APPEND_B, 32'd9);
    add_req(CMD_MERGE, 32'h0, 1'b1);
    // unsorted list a
    add_req(CMD_APPEND_A, 32'd10);
    add_req(CMD_APPEND_A, 32'd2);
    add_req(CMD_APPEND_B, 32'd4);
    add_req(CMD_MERGE, 32'h0);
    add_req(CMD_UNUSED, 32'h0);

    // random loads without overflow, so the drop flag stays clear for a while
    while (fed_count < 170) add_run(pick_size(), pick_size());
    // try to overflow list a, then list b; once set, the drop flag must stick
    add_run(LIST_DEPTH + $urandom_range(1, 3), $urandom_range(0, 4));
    add_run($urandom_range(0, 4), LIST_DEPTH + $urandom_range(1, 3));
    while (fed_count < 250) add_run(pick_size(), pick_size());

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (merged_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (bad_count == 0 && merged_due.size() == 0) begin
      $display("[sorted_two_way_merge] OK");
    end else begin
      $display("[sorted_two_way_merge] ERROR");
    end
    $finish;
  end

endmodule
